### design/csvrfs_pkg.sv
// Package for the CSV row field splitter.
// Holds the parser mode type, character codes, default buffer sizes and the header word.
// No dependencies.
`default_nettype none

package csvrfs_pkg;

  typedef enum logic [2:0] {
    MODE_START      = 3'd0,
    MODE_UNQUOTED   = 3'd1,
    MODE_QUOTED     = 3'd2,
    MODE_QUOTE_PEND = 3'd3,
    MODE_STOPPED    = 3'd4,
    MODE_DONE       = 3'd5
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] FIELD_TIME  = 3'd0;
  localparam logic [2:0] FIELD_MAP   = 3'd2;
  localparam logic [2:0] FIELD_COUNT = 3'd4;

  localparam logic       KIND_CHAR    = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam int TIME_BUF_DEF    = 32;
  localparam int PLAYERS_BUF_DEF = 256;
  localparam int MAP_BUF_DEF     = 128;
  localparam int CODE_BUF_DEF    = 64;
  localparam int LINE_BUF_DEF    = 512;

  localparam logic [4:0] TIME_LEN_MAX   = 5'd31;
  localparam logic [4:0] HEADER_LEN     = 5'd4;
  localparam logic [7:0] FIELD_LEN_MAX  = 8'd255;

  // Lower-case letters of the header word "time".
  function automatic logic [7:0] header_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0: ch = 8'h74;
      2'd1: ch = 8'h69;
      2'd2: ch = 8'h6D;
      2'd3: ch = 8'h65;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] ch);
    logic [7:0] lc;
    lc = ch;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      lc = ch + 8'd32;
    end
    return lc;
  endfunction

endpackage

`default_nettype wire

### design/csv_row_field_splitter.sv
// CSV row field splitter top level: one-byte-per-cycle quoted field parser while the output is not stalled.
// Depends on csvrfs_pkg for the mode type, character codes and header word.
//
//   channel | valid    | ready     | payload
//   input   | in_valid | in_ready  | char_byte, end_of_line
//   output  | out_valid| out_ready | kind, field_index, out_char, row_valid
//
// The parser state updates in the cycle a request is accepted.
// The result sits in one output register, so a new request is taken whenever that
// register is empty or being drained in the same cycle.
// Reset is synchronous and returns the parser to the start of a line.
// An end-of-line request yields the row verdict and clears the parser.
`default_nettype none

module csv_row_field_splitter #(
  parameter int TIME_BUF    = csvrfs_pkg::TIME_BUF_DEF,
  parameter int PLAYERS_BUF = csvrfs_pkg::PLAYERS_BUF_DEF,
  parameter int MAP_BUF     = csvrfs_pkg::MAP_BUF_DEF,
  parameter int CODE_BUF    = csvrfs_pkg::CODE_BUF_DEF,
  parameter int LINE_BUF    = csvrfs_pkg::LINE_BUF_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_line,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [1:0]      field_index,
  output logic [7:0]      out_char,
  output logic            row_valid
);

  localparam int LINE_W = $clog2(LINE_BUF);
  localparam logic [LINE_W-1:0] LINE_LIMIT  = LINE_W'(LINE_BUF - 1);
  localparam logic [8:0]        TIME_CAP    = 9'(TIME_BUF);
  localparam logic [8:0]        PLAYERS_CAP = 9'(PLAYERS_BUF);
  localparam logic [8:0]        MAP_CAP     = 9'(MAP_BUF);
  localparam logic [8:0]        CODE_CAP    = 9'(CODE_BUF);

  csvrfs_pkg::mode_t parse_mode, parse_mode_next;
  logic [2:0]        current_field, current_field_next;
  logic [7:0]        field_length, field_length_next;
  logic [LINE_W-1:0] line_length;
  logic [4:0]        time_length, time_length_next;
  logic              time_header_match, time_header_match_next;
  logic              map_nonempty, map_nonempty_next;

  logic              in_accept;
  logic              line_live;
  logic              is_term;
  logic              do_start;
  logic              do_keep;
  logic [7:0]        keep_char;
  logic [2:0]        keep_field;
  logic [7:0]        keep_length;
  logic [8:0]        keep_cap;
  logic              keep_fits;
  logic              emit_char;
  logic              header_row;
  logic              verdict;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign line_live = line_length < LINE_LIMIT;
  assign is_term   = (char_byte == csvrfs_pkg::CH_NUL) || (char_byte == csvrfs_pkg::CH_CR) ||
                     (char_byte == csvrfs_pkg::CH_LF);

  // Next-state decode of the parser for one byte.
  always_comb begin
    parse_mode_next    = parse_mode;
    current_field_next = current_field;
    field_length_next  = field_length;
    do_start           = 1'b0;
    do_keep            = 1'b0;
    keep_char          = char_byte;
    keep_field         = current_field;
    keep_length        = field_length;
    unique case (parse_mode)
      csvrfs_pkg::MODE_START: begin
        do_start = 1'b1;
      end
      csvrfs_pkg::MODE_UNQUOTED: begin
        if (char_byte == csvrfs_pkg::CH_COMMA) begin
          current_field_next = current_field + 3'd1;
          field_length_next  = '0;
          parse_mode_next    = (current_field + 3'd1 >= csvrfs_pkg::FIELD_COUNT) ?
                               csvrfs_pkg::MODE_DONE : csvrfs_pkg::MODE_START;
        end else if (is_term) begin
          parse_mode_next = csvrfs_pkg::MODE_STOPPED;
        end else begin
          do_keep = 1'b1;
        end
      end
      csvrfs_pkg::MODE_QUOTED: begin
        if (char_byte == csvrfs_pkg::CH_NUL) begin
          parse_mode_next = csvrfs_pkg::MODE_STOPPED;
        end else if (char_byte == csvrfs_pkg::CH_QUOTE) begin
          parse_mode_next = csvrfs_pkg::MODE_QUOTE_PEND;
        end else begin
          do_keep = 1'b1;
        end
      end
      csvrfs_pkg::MODE_QUOTE_PEND: begin
        if (char_byte == csvrfs_pkg::CH_QUOTE) begin
          parse_mode_next = csvrfs_pkg::MODE_QUOTED;
          do_keep         = 1'b1;
          keep_char       = csvrfs_pkg::CH_QUOTE;
        end else begin
          current_field_next = current_field + 3'd1;
          field_length_next  = '0;
          keep_field         = current_field + 3'd1;
          keep_length        = '0;
          if (current_field + 3'd1 >= csvrfs_pkg::FIELD_COUNT) begin
            parse_mode_next = csvrfs_pkg::MODE_DONE;
          end else if (char_byte == csvrfs_pkg::CH_COMMA) begin
            parse_mode_next = csvrfs_pkg::MODE_START;
          end else begin
            do_start = 1'b1;
          end
        end
      end
      csvrfs_pkg::MODE_STOPPED, csvrfs_pkg::MODE_DONE: begin
        parse_mode_next = parse_mode;
      end
      default: begin
        parse_mode_next = parse_mode;
      end
    endcase
    if (do_start) begin
      if (is_term) begin
        parse_mode_next = csvrfs_pkg::MODE_STOPPED;
      end else if (char_byte == csvrfs_pkg::CH_QUOTE) begin
        parse_mode_next = csvrfs_pkg::MODE_QUOTED;
      end else if (char_byte == csvrfs_pkg::CH_COMMA) begin
        current_field_next = keep_field + 3'd1;
        field_length_next  = '0;
        parse_mode_next    = (keep_field + 3'd1 >= csvrfs_pkg::FIELD_COUNT) ?
                             csvrfs_pkg::MODE_DONE : csvrfs_pkg::MODE_START;
      end else begin
        parse_mode_next = csvrfs_pkg::MODE_UNQUOTED;
        do_keep         = 1'b1;
      end
    end
    if (do_keep) begin
      field_length_next = (keep_length < csvrfs_pkg::FIELD_LEN_MAX) ?
                          keep_length + 8'd1 : keep_length;
    end
  end

  // Kept-character bookkeeping and row verdict.
  always_comb begin
    unique case (keep_field[1:0])
      2'd0: keep_cap = TIME_CAP;
      2'd1: keep_cap = PLAYERS_CAP;
      2'd2: keep_cap = MAP_CAP;
      2'd3: keep_cap = CODE_CAP;
      default: keep_cap = CODE_CAP;
    endcase
    keep_fits              = ({1'b0, keep_length} + 9'd1) < keep_cap;
    emit_char              = do_keep && keep_fits;
    time_length_next       = time_length;
    time_header_match_next = time_header_match;
    map_nonempty_next      = map_nonempty;
    if (emit_char && keep_field == csvrfs_pkg::FIELD_TIME) begin
      if (keep_length >= 8'd4 ||
          csvrfs_pkg::fold_case(keep_char) != csvrfs_pkg::header_char(keep_length[1:0])) begin
        time_header_match_next = 1'b0;
      end
      if (time_length < csvrfs_pkg::TIME_LEN_MAX) begin
        time_length_next = time_length + 5'd1;
      end
    end
    if (emit_char && keep_field == csvrfs_pkg::FIELD_MAP) begin
      map_nonempty_next = 1'b1;
    end
    header_row = time_header_match && (time_length == csvrfs_pkg::HEADER_LEN);
    verdict    = (time_length != '0) && map_nonempty && !header_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode        <= csvrfs_pkg::MODE_START;
      current_field     <= '0;
      field_length      <= '0;
      line_length       <= '0;
      time_length       <= '0;
      time_header_match <= 1'b1;
      map_nonempty      <= 1'b0;
    end else if (in_accept) begin
      if (end_of_line) begin
        parse_mode        <= csvrfs_pkg::MODE_START;
        current_field     <= '0;
        field_length      <= '0;
        line_length       <= '0;
        time_length       <= '0;
        time_header_match <= 1'b1;
        map_nonempty      <= 1'b0;
      end else if (line_live) begin
        parse_mode        <= parse_mode_next;
        current_field     <= current_field_next;
        field_length      <= field_length_next;
        line_length       <= line_length + LINE_W'(1);
        time_length       <= time_length_next;
        time_header_match <= time_header_match_next;
        map_nonempty      <= map_nonempty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= end_of_line || (line_live && emit_char);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (end_of_line) begin
        kind        <= csvrfs_pkg::KIND_VERDICT;
        field_index <= '0;
        out_char    <= '0;
        row_valid   <= verdict;
      end else begin
        kind        <= csvrfs_pkg::KIND_CHAR;
        field_index <= keep_field[1:0];
        out_char    <= keep_char;
        row_valid   <= 1'b0;
      end
    end
  end

  a_done_at_last_field: assert property (@(posedge clk) disable iff (rst)
    (parse_mode == csvrfs_pkg::MODE_DONE) == (current_field == csvrfs_pkg::FIELD_COUNT))
    else $error("parser mode and field count disagree");

  a_verdict_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == csvrfs_pkg::KIND_VERDICT) |-> (out_char == '0 && field_index == '0))
    else $error("verdict carries a character");

  a_char_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == csvrfs_pkg::KIND_CHAR) |-> !row_valid)
    else $error("character result carries a verdict");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && end_of_line) |=>
      (line_length == '0 && parse_mode == csvrfs_pkg::MODE_START && current_field == '0))
    else $error("end of line did not clear the parser");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while a result is stalled");

endmodule

`default_nettype wire

### test/csv_row_field_splitter_tb.sv
// Testbench for csv_row_field_splitter: byte-wise CSV rows in, kept characters and row
// verdicts out, checked against a cycle-free predictor kept in this module.
// Depends on csvrfs_pkg and the csv_row_field_splitter RTL.
module csv_row_field_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_CAP     = csvrfs_pkg::TIME_BUF_DEF;
  localparam int PLAYERS_CAP  = csvrfs_pkg::PLAYERS_BUF_DEF;
  localparam int MAP_CAP      = csvrfs_pkg::MAP_BUF_DEF;
  localparam int CODE_CAP     = csvrfs_pkg::CODE_BUF_DEF;
  localparam int LINE_CAP     = csvrfs_pkg::LINE_BUF_DEF;
  localparam int RANDOM_ITEMS = 1850;
  localparam logic [31:0] HDR_WORD = "time";

  typedef struct packed {
    logic       kind;
    logic [1:0] fidx;
    logic [7:0] ch;
    logic       valid;
  } split_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    bit         hold;
  } send_item_t;

  typedef enum int {FS_EMPTY, FS_PLAIN, FS_QUOTED} fstyle_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_byte = 8'h00;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [1:0] field_index;
  logic [7:0] out_char;
  logic       row_valid;

  csvrfs_pkg::mode_t pmode = csvrfs_pkg::MODE_START;
  int    fld = 0;
  int    flen = 0;
  int    llen = 0;
  int    tlen = 0;
  bit    hdr_ok = 1'b1;
  bit    map_seen = 1'b0;

  split_res_t exp_q[$];
  send_item_t pend_q[$];
  bit  drain_next = 1'b0;
  bit  in_fire = 1'b0;
  bit  out_fire = 1'b0;
  bit  long_hold = 1'b0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;
  int  send_wait = 0;
  int  recv_wait = 0;
  int  items_taken = 0;
  int  total_items = 0;
  int  err_count = 0;
  int  n_chars = 0;
  int  n_rows = 0;

  csv_row_field_splitter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_byte(char_byte),
    .end_of_line(end_of_line),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .field_index(field_index),
    .out_char(out_char),
    .row_valid(row_valid)
  );

  function automatic int cap_of(input int f);
    case (f)
      0: return TIME_CAP;
      1: return PLAYERS_CAP;
      2: return MAP_CAP;
      default: return CODE_CAP;
    endcase
  endfunction

  function automatic void clear_parser();
    pmode = csvrfs_pkg::MODE_START;
    fld = 0;
    flen = 0;
    llen = 0;
    tlen = 0;
    hdr_ok = 1'b1;
    map_seen = 1'b0;
  endfunction

  function automatic void advance_field();
    fld++;
    flen = 0;
    pmode = (fld >= csvrfs_pkg::FIELD_COUNT) ? csvrfs_pkg::MODE_DONE : csvrfs_pkg::MODE_START;
  endfunction

  function automatic bit take_char(input logic [7:0] c, output split_res_t r);
    int pos;
    logic [7:0] lc;
    r = '0;
    pos = flen;
    if (flen < csvrfs_pkg::FIELD_LEN_MAX) flen++;
    if (pos + 1 >= cap_of(fld)) return 1'b0;
    if (fld == csvrfs_pkg::FIELD_TIME) begin
      lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
      if (pos >= 4) begin
        hdr_ok = 1'b0;
      end else if (lc != HDR_WORD[31 - 8 * pos -: 8]) begin
        hdr_ok = 1'b0;
      end
      if (tlen < csvrfs_pkg::TIME_LEN_MAX) tlen++;
    end else if (fld == csvrfs_pkg::FIELD_MAP) begin
      map_seen = 1'b1;
    end
    r.kind = csvrfs_pkg::KIND_CHAR;
    r.fidx = fld[1:0];
    r.ch = c;
    return 1'b1;
  endfunction

  function automatic bit open_field(input logic [7:0] c, output split_res_t r);
    r = '0;
    if (c == csvrfs_pkg::CH_NUL || c == csvrfs_pkg::CH_CR || c == csvrfs_pkg::CH_LF) begin
      pmode = csvrfs_pkg::MODE_STOPPED;
      return 1'b0;
    end
    if (c == csvrfs_pkg::CH_QUOTE) begin
      pmode = csvrfs_pkg::MODE_QUOTED;
      return 1'b0;
    end
    if (c == csvrfs_pkg::CH_COMMA) begin
      advance_field();
      return 1'b0;
    end
    pmode = csvrfs_pkg::MODE_UNQUOTED;
    return take_char(c, r);
  endfunction

  function automatic bit split_predict(input logic [7:0] c, input logic eol,
                                       output split_res_t r);
    bit hdr;
    r = '0;
    if (eol) begin
      hdr = hdr_ok && tlen == csvrfs_pkg::HEADER_LEN;
      r.kind = csvrfs_pkg::KIND_VERDICT;
      r.valid = tlen > 0 && map_seen && !hdr;
      clear_parser();
      return 1'b1;
    end
    if (llen >= LINE_CAP - 1) return 1'b0;
    llen++;
    case (pmode)
      csvrfs_pkg::MODE_START: return open_field(c, r);
      csvrfs_pkg::MODE_UNQUOTED: begin
        if (c == csvrfs_pkg::CH_COMMA) begin
          advance_field();
          return 1'b0;
        end
        if (c == csvrfs_pkg::CH_NUL || c == csvrfs_pkg::CH_CR || c == csvrfs_pkg::CH_LF) begin
          pmode = csvrfs_pkg::MODE_STOPPED;
          return 1'b0;
        end
        return take_char(c, r);
      end
      csvrfs_pkg::MODE_QUOTED: begin
        if (c == csvrfs_pkg::CH_NUL) begin
          pmode = csvrfs_pkg::MODE_STOPPED;
          return 1'b0;
        end
        if (c == csvrfs_pkg::CH_QUOTE) begin
          pmode = csvrfs_pkg::MODE_QUOTE_PEND;
          return 1'b0;
        end
        return take_char(c, r);
      end
      csvrfs_pkg::MODE_QUOTE_PEND: begin
        if (c == csvrfs_pkg::CH_QUOTE) begin
          pmode = csvrfs_pkg::MODE_QUOTED;
          return take_char(csvrfs_pkg::CH_QUOTE, r);
        end
        advance_field();
        if (c == csvrfs_pkg::CH_COMMA || pmode == csvrfs_pkg::MODE_DONE) return 1'b0;
        return open_field(c, r);
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string fmt_res(input split_res_t r);
    return $sformatf("kind=%0d field=%0d char=%02h row_valid=%0d",
                     r.kind, r.fidx, r.ch, r.valid);
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic add_byte(input logic [7:0] c);
    send_item_t it;
    it.ch = c;
    it.eol = 1'b0;
    it.hold = drain_next;
    drain_next = 1'b0;
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic add_eol();
    send_item_t it;
    it.ch = 8'($urandom_range(0, 255));
    it.eol = 1'b1;
    it.hold = drain_next;
    drain_next = 1'b0;
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte(input bit lead);
    logic [7:0] c;
    c = csvrfs_pkg::CH_COMMA;
    while (c == csvrfs_pkg::CH_COMMA || c == csvrfs_pkg::CH_CR || c == csvrfs_pkg::CH_LF ||
           c == csvrfs_pkg::CH_NUL || (lead && c == csvrfs_pkg::CH_QUOTE))
      c = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] quoted_byte();
    case ($urandom_range(0, 7))
      0: return csvrfs_pkg::CH_COMMA;
      1: return $urandom_range(0, 1) ? csvrfs_pkg::CH_CR : csvrfs_pkg::CH_LF;
      2: return csvrfs_pkg::CH_QUOTE;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic add_field(input fstyle_t style, input int len, input bit closed);
    int i;
    logic [7:0] c;
    if (style == FS_QUOTED) begin
      add_byte(csvrfs_pkg::CH_QUOTE);
      for (i = 0; i < len; i++) begin
        c = ($urandom_range(0, 59) == 0) ? csvrfs_pkg::CH_NUL : quoted_byte();
        add_byte(c);
        if (c == csvrfs_pkg::CH_QUOTE) add_byte(csvrfs_pkg::CH_QUOTE);
      end
      if (closed) add_byte(csvrfs_pkg::CH_QUOTE);
    end else if (style == FS_PLAIN) begin
      for (i = 0; i < len; i++) add_byte(plain_byte(i == 0));
    end
  endtask

  task automatic add_header_word(input bit quoted);
    int i;
    logic [7:0] c;
    if (quoted) add_byte(csvrfs_pkg::CH_QUOTE);
    for (i = 0; i < 4; i++) begin
      c = HDR_WORD[31 - 8 * i -: 8];
      if ($urandom_range(0, 1)) c = c - 8'd32;
      add_byte(c);
    end
    if ($urandom_range(0, 3) == 0) add_byte(plain_byte(1'b0));
    if (quoted) add_byte(csvrfs_pkg::CH_QUOTE);
  endtask

  task automatic add_row();
    int nf;
    int f;
    int len;
    int pick;
    fstyle_t style;
    bit after_quote;
    pick = $urandom_range(0, 19);
    nf = (pick < 14) ? 4 : (pick < 17) ? $urandom_range(5, 6) : $urandom_range(1, 3);
    after_quote = 1'b0;
    for (f = 0; f < nf; f++) begin
      if (f > 0 && !(after_quote && $urandom_range(0, 7) == 0))
        add_byte(csvrfs_pkg::CH_COMMA);
      pick = $urandom_range(0, 15);
      style = (pick < 2) ? FS_EMPTY : (pick < 9) ? FS_PLAIN : FS_QUOTED;
      len = ($urandom_range(0, 39) == 0) ?
            $urandom_range(cap_of(f) - 2, cap_of(f) + 3) : $urandom_range(1, 6);
      if (f == 0 && $urandom_range(0, 4) == 0) begin
        add_header_word(style == FS_QUOTED);
      end else begin
        add_field(style, len, $urandom_range(0, 14) != 0);
      end
      after_quote = (style == FS_QUOTED);
    end
    case ($urandom_range(0, 7))
      0: begin
        add_byte(csvrfs_pkg::CH_CR);
        add_byte(csvrfs_pkg::CH_LF);
      end
      1: add_byte(csvrfs_pkg::CH_LF);
      2: add_byte(csvrfs_pkg::CH_NUL);
      3: begin
        add_byte(csvrfs_pkg::CH_CR);
        add_byte(plain_byte(1'b0));
      end
      default: ;
    endcase
    add_eol();
  endtask

  task automatic add_noise();
    int i;
    int len;
    len = $urandom_range(0, 16);
    for (i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
    add_eol();
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin : drive_p
    send_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
    end else if (send_wait > 0) begin
      in_valid <= 1'b0;
      send_wait--;
    end else if (pend_q.size() != 0 && (!pend_q[0].hold || exp_q.size() == 0)) begin
      it = pend_q.pop_front();
      char_byte <= it.ch;
      end_of_line <= it.eol;
      in_valid <= 1'b1;
      if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
      send_wait = send_burst ? 0 : $urandom_range(0, 7);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 7);
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_p
    split_res_t want;
    split_res_t got;
    in_fire = 1'b0;
    out_fire = 1'b0;
    if (rst) begin
      clear_parser();
    end else begin
      if (out_valid && out_ready) begin
        out_fire = 1'b1;
        got = {kind, field_index, out_char, row_valid};
        if (exp_q.size() == 0) begin
          note_failure({"unexpected result ", fmt_res(got)});
        end else begin
          want = exp_q.pop_front();
          if (got.kind !== want.kind || got.fidx !== want.fidx ||
              got.ch !== want.ch || got.valid !== want.valid)
            note_failure({"mismatch: expected ", fmt_res(want), ", got ", fmt_res(got)});
          if (want.kind == csvrfs_pkg::KIND_VERDICT) n_rows++;
          else n_chars++;
        end
      end
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        items_taken++;
        if (split_predict(char_byte, end_of_line, want)) exp_q.insert(exp_q.size(), want);
      end
    end
  end

  // Hold the output off long enough for the result register to fill and stall the input.
  initial begin
    while (items_taken < 1000) @(posedge clk);
    long_hold = 1'b1;
    repeat (80) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results still outstanding.", exp_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_p
    drain_next = 1'b1;
    add_text("TiME,,m");
    add_eol();
    add_text("\"a\"\"\"x,m");
    add_byte(csvrfs_pkg::CH_CR);
    add_eol();
    add_byte(8'hFF);
    add_byte(csvrfs_pkg::CH_NUL);
    add_eol();
    add_byte(8'hD4);
    add_byte(csvrfs_pkg::CH_COMMA);
    add_byte(csvrfs_pkg::CH_COMMA);
    add_byte(8'h80);
    add_eol();

    drain_next = 1'b1;
    add_field(FS_PLAIN, TIME_CAP + 8, 1'b1);
    add_byte(csvrfs_pkg::CH_COMMA);
    add_field(FS_QUOTED, PLAYERS_CAP + 44, 1'b1);
    add_byte(csvrfs_pkg::CH_COMMA);
    add_field(FS_PLAIN, MAP_CAP + 12, 1'b1);
    add_byte(csvrfs_pkg::CH_COMMA);
    add_field(FS_PLAIN, CODE_CAP + 16, 1'b1);
    add_eol();
    while (pend_q.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) drain_next = 1'b1;
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_row();
    end
    total_items = pend_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (items_taken < total_items) @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests; checked %0d kept characters and %0d row verdicts.",
             items_taken, n_chars, n_rows);
    $display("Rows mixed quoting, header words, field and line overflow, and noise.");
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d failures in total.", err_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### csv_row_field_splitter.f
design/csvrfs_pkg.sv
design/csv_row_field_splitter.sv
test/csv_row_field_splitter_tb.sv
